FILE: rtl/ocl_pkg.sv
// Shared types and constants for the ordered child list.
// No dependencies; every other file imports this package.
package ocl_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned ORD_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_READOUT = 2'd2,
    OP_REORDER = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // One stored list entry
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ORD_W-1:0] order;
  } entry_t;

  // Command as captured from the input channel
  typedef struct packed {
    op_e              op;
    logic [ID_W-1:0]  id;
    logic [ORD_W-1:0] order;
  } cmd_t;

  // Result payload
  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     entry_id;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } rsp_t;

endpackage

FILE: rtl/ocl_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on ocl_pkg for field widths.
interface ocl_cmd_if;
  import ocl_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ID_W-1:0]  child_id;
  logic [ORD_W-1:0] order_value;

  modport source (output valid, operation, child_id, order_value, input ready);
  modport sink   (input valid, operation, child_id, order_value, output ready);
endinterface

interface ocl_rsp_if;
  import ocl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     entry_id;
  logic [COUNT_W-1:0]  entry_count;
  logic                last;

  modport source (output valid, status, entry_id, entry_count, last, input ready);
  modport sink   (input valid, status, entry_id, entry_count, last, output ready);
endinterface

FILE: rtl/ordered_child_list.sv
// Ordered child list: keeps up to LIST_DEPTH (id, order) pairs sorted by
// signed order, equal orders in arrival order. Commands are taken one at a
// time; the input is not ready while a command is in progress. Each stored
// entry touched costs one store read and one compare/write: insert walks
// back from the tail over the entries of greater order, remove and the
// removal scan of reorder visit every held entry, reorder then inserts,
// and readout gives one entry per store read, waiting while the output
// register holds an untaken result. A full list rejects an
// insert with status "list full". The store has no reset; the fill count
// alone marks which entries are live. Results sit in an output register so
// the sequencer keeps going while the last result waits to be taken.
// Depends on ocl_pkg, ocl_if, ocl_mem and ocl_seq.
module ordered_child_list #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ocl_cmd_if.sink   cmd_i,
  ocl_rsp_if.source rsp_o
);
  import ocl_pkg::*;

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  cmd_t  cmd;
  rsp_t  rsp_next;
  rsp_t  rsp_q;
  logic  rsp_valid_q;
  logic  out_free;
  logic  push;

  assign cmd = '{op: op_e'(cmd_i.operation), id: cmd_i.child_id, order: cmd_i.order_value};
  assign out_free = !rsp_valid_q || rsp_o.ready;

  ocl_seq #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_i       (cmd),
    .out_free_i  (out_free),
    .push_o      (push),
    .rsp_o       (rsp_next)
  );

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (push) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.entry_id    = rsp_q.entry_id;
  assign rsp_o.entry_count = rsp_q.entry_count;
  assign rsp_o.last        = rsp_q.last;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> (rsp_valid_q && $stable(rsp_q)))
    else $error("stalled result changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!rsp_valid_q || rsp_o.ready))
    else $error("pending result overwritten");

  a_busy_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !(cmd_i.valid && cmd_i.ready))
    else $error("command taken while a result is produced");

endmodule

FILE: rtl/ocl_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on ocl_pkg for the entry type.
module ocl_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ocl_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output ocl_pkg::entry_t rdata_o
);
  import ocl_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Write port and read port, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ocl_seq.sv
// Sequencer for the ordered child list: walks the entry store one entry
// per read with a single id/order compare unit. Depends on ocl_pkg, ocl_mem.
module ocl_seq #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  ocl_pkg::cmd_t  cmd_i,
  input  logic           out_free_i,
  output logic           push_o,
  output ocl_pkg::rsp_t  rsp_o
);
  import ocl_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_RM_RD    = 8'b0000_0010,
    S_RM_CHK   = 8'b0000_0100,
    S_INS_RD   = 8'b0000_1000,
    S_INS_CHK  = 8'b0001_0000,
    S_LIST_RD  = 8'b0010_0000,
    S_LIST_OUT = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            found_q, found_d;
  status_e         status_q, status_d;
  cmd_t            cmd_q, cmd_d;

  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic [AW-1:0]   raddr;
  entry_t          rdata;

  logic [CW-1:0]   idx_m1;
  logic [CW-1:0]   idx_p1;
  logic [CW-1:0]   cnt_rm;
  logic [CW+4:0]   cnt_ext;
  logic            cnt_full;
  logic            id_eq;
  logic            ord_gt;
  entry_t          new_entry;

  ocl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared compare unit and index arithmetic
  assign id_eq     = (rdata.id == cmd_q.id);
  assign ord_gt    = $signed(rdata.order) > $signed(cmd_q.order);
  assign idx_m1    = idx_q - CW'(1);
  assign idx_p1    = idx_q + CW'(1);
  assign cnt_rm    = cnt_q - CW'(found_q);
  assign cnt_full  = (cnt_q == CW'(DEPTH));
  assign cnt_ext   = {5'b0, cnt_q};
  assign new_entry = '{id: cmd_q.id, order: cmd_q.order};

  // Insert walks from the tail backward, so it reads one below idx
  assign raddr = (state_q == S_INS_RD) ? idx_m1[AW-1:0] : idx_q[AW-1:0];

  assign cmd_ready_o = (state_q == S_IDLE);

  // Next-state logic
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    status_d = status_q;
    cmd_d    = cmd_q;
    we       = 1'b0;
    waddr    = idx_q[AW-1:0];
    wdata    = rdata;
    push_o   = 1'b0;
    rsp_o    = '{status: status_q, entry_id: '0, entry_count: cnt_ext[4:0], last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.op)
            OP_INSERT: begin
              if (cnt_full) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end
            end
            OP_REMOVE, OP_REORDER: begin
              idx_d   = '0;
              found_d = 1'b0;
              state_d = S_RM_RD;
            end
            OP_READOUT: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                idx_d   = '0;
                state_d = S_LIST_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Removal scan: find the first match, then pull later entries down
      S_RM_RD: begin
        if (idx_q == cnt_q) begin
          cnt_d = cnt_rm;
          if (cmd_q.op == OP_REMOVE) begin
            status_d = found_q ? ST_DONE : ST_NOTFOUND;
            state_d  = S_RESP;
          end else if (cnt_rm == CW'(DEPTH)) begin
            status_d = ST_FULL;
            state_d  = S_RESP;
          end else begin
            idx_d   = cnt_rm;
            state_d = S_INS_RD;
          end
        end else begin
          state_d = S_RM_CHK;
        end
      end

      S_RM_CHK: begin
        if (found_q) begin
          we    = 1'b1;
          waddr = idx_m1[AW-1:0];
          wdata = rdata;
        end else if (id_eq) begin
          found_d = 1'b1;
        end
        idx_d   = idx_p1;
        state_d = S_RM_RD;
      end

      // Insert: shift greater entries up one slot, then drop in the new one
      S_INS_RD: begin
        if (idx_q == '0) begin
          we       = 1'b1;
          waddr    = '0;
          wdata    = new_entry;
          cnt_d    = cnt_q + CW'(1);
          status_d = ST_DONE;
          state_d  = S_RESP;
        end else begin
          state_d = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        we = 1'b1;
        if (ord_gt) begin
          wdata   = rdata;
          idx_d   = idx_m1;
          state_d = S_INS_RD;
        end else begin
          wdata    = new_entry;
          cnt_d    = cnt_q + CW'(1);
          status_d = ST_DONE;
          state_d  = S_RESP;
        end
      end

      S_LIST_RD: begin
        state_d = S_LIST_OUT;
      end

      // One result per held entry
      S_LIST_OUT: begin
        if (out_free_i) begin
          push_o = 1'b1;
          rsp_o  = '{status: ST_ENTRY, entry_id: rdata.id, entry_count: cnt_ext[4:0],
                     last: (idx_p1 == cnt_q)};
          if (idx_p1 == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_p1;
            state_d = S_LIST_RD;
          end
        end
      end

      S_RESP: begin
        if (out_free_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    found_q  <= found_d;
    status_q <= status_d;
    cmd_q    <= cmd_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above list depth");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed into a busy output register");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && rsp_o.last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after final result");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we)
    else $error("entry store written while idle");

endmodule
